@@ src/bts_pkg.sv @@
package bts_pkg;

	localparam int unsigned MAX_DIM_DEF   = 256;
	localparam int unsigned FRAC_BITS_DEF = 16;

	// result queue depth, also the most samples that may be past issue and not yet taken at rsp
	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [15:0] FULL_OUT = 16'hFF00;

	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] alpha;
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} rgba_t;

	// the four corner texels of one sample footprint
	typedef struct packed {
		logic [31:0] t11;
		logic [31:0] t01;
		logic [31:0] t10;
		logic [31:0] t00;
	} quad_t;

	// channel count is already normalized to 1..4
	function automatic logic [3:0][7:0] expand_texel(input logic [31:0] word,
		input logic [2:0] chans);
		logic [3:0][7:0] res;
		res[0] = word[7:0];
		res[1] = (chans >= 3'd2) ? word[15:8]  : word[7:0];
		res[2] = (chans >= 3'd3) ? word[23:16] : word[7:0];
		res[3] = (chans >= 3'd4) ? word[31:24] : 8'hFF;
		return res;
	endfunction

endpackage

@@ src/bts_cfg_if.sv @@
interface bts_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/bts_req_if.sv @@
interface bts_req_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [15:0]        texel_address;
	logic [31:0]        texel_value;
	logic signed [23:0] u_coord;
	logic signed [23:0] v_coord;

	modport source (output valid, output operation, output texel_address,
		output texel_value, output u_coord, output v_coord, input ready);
	modport sink (input valid, input operation, input texel_address,
		input texel_value, input u_coord, input v_coord, output ready);
endinterface

@@ src/bts_rsp_if.sv @@
interface bts_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic [15:0] alpha;

	modport source (output valid, output red, output green, output blue,
		output alpha, input ready);
	modport sink (input valid, input red, input green, input blue,
		input alpha, output ready);
endinterface

@@ src/bilinear_texture_sampler_core.sv @@
// bilinear texture sampler with repeat wrap
// cfg: register writes (0 width, 1 height, 2 channel count), always ready; write
//   only while no transaction is in progress. width or height zero gives white.
// req: operation 0 writes texel_value at texel_address, operation 1 samples at
//   u_coord/v_coord (signed, FRAC_BITS fraction bits). a load gives no result.
// rsp: one color per sample, byte value times 256 per channel, in request order.
// issue: a textured sample holds the issue stage while it reads its four corner
//   texels in turn from the single-port texture memory; a load or an
//   untextured sample needs no reads. requests are taken while earlier samples
//   are still being read, blended or waiting at rsp.
// path: a sample goes through stage 1, stage 2, the issue stage, the blend
//   stages and the result queue before it shows at rsp.
// stall: a four-entry result queue drives rsp; a sample starts its reads only
//   when a queue entry is free for it, so a stalled rsp backs up into req.
// reset: width and height clear to zero, channel count to 4; the texture
//   memory is not cleared and holds nothing defined until loaded.
module bilinear_texture_sampler_core #(
	parameter int unsigned MAX_DIM   = bts_pkg::MAX_DIM_DEF,
	parameter int unsigned FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bts_cfg_if.sink   cfg,
	bts_req_if.sink   req,
	bts_rsp_if.source rsp
);
	import bts_pkg::*;

	localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
	localparam int unsigned IDX_W  = $clog2(MAX_DIM);
	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CMP_W  = (DIM_W > 9) ? DIM_W : 9;
	localparam int unsigned TX_W   = FRAC_BITS + DIM_W;
	localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);

	function automatic logic [DIM_W-1:0] sat_dim(input logic [8:0] v);
		return (CMP_W'(v) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(v);
	endfunction

	// configuration
	logic [DIM_W-1:0] width_q, height_q;
	logic [2:0]       chans_q;
	logic [DIM_W-1:0] wm1, hm1;
	logic             no_tex;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			chans_q  <= 3'd4;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_WIDTH: begin
					width_q <= sat_dim(cfg.data);
				end
				REG_HEIGHT: begin
					height_q <= sat_dim(cfg.data);
				end
				REG_CHANNELS: begin
					if (cfg.data[2:0] == 3'd0) chans_q <= 3'd1;
					else if (cfg.data[2:0] > 3'd4) chans_q <= 3'd4;
					else chans_q <= cfg.data[2:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign wm1    = width_q - DIM_W'(1);
	assign hm1    = height_q - DIM_W'(1);
	assign no_tex = (width_q == '0) || (height_q == '0);

	// stage 1: scale wrapped fractions by size minus one
	logic              v_s1, op_s1, white_s1;
	logic [15:0]       taddr_s1;
	logic [31:0]       tval_s1;
	logic [TX_W-1:0]   tx_s1, ty_s1;
	logic              ready_s1, ready_s2, ready_s3;

	assign ready_s1  = !v_s1 || ready_s2;
	assign req.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (ready_s1) v_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && ready_s1) begin
			op_s1    <= req.operation;
			white_s1 <= no_tex;
			taddr_s1 <= req.texel_address;
			tval_s1  <= req.texel_value;
			tx_s1    <= TX_W'(req.u_coord[FRAC_BITS-1:0]) * TX_W'(wm1);
			ty_s1    <= TX_W'(req.v_coord[FRAC_BITS-1:0]) * TX_W'(hm1);
		end
	end

	// stage 2: texel indices and weights
	logic [IDX_W-1:0]     x0_d, y0_d, wlast, hlast;
	logic                 v_s2, op_s2, white_s2;
	logic [15:0]          taddr_s2;
	logic [31:0]          tval_s2;
	logic [IDX_W-1:0]     x0_s2, x1_s2, y0_s2, y1_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2;

	assign x0_d  = tx_s1[FRAC_BITS +: IDX_W];
	assign y0_d  = ty_s1[FRAC_BITS +: IDX_W];
	assign wlast = IDX_W'(wm1);
	assign hlast = IDX_W'(hm1);

	assign ready_s2 = !v_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (ready_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			op_s2    <= op_s1;
			white_s2 <= white_s1;
			taddr_s2 <= taddr_s1;
			tval_s2  <= tval_s1;
			x0_s2    <= x0_d;
			y0_s2    <= y0_d;
			// next texel clamps to the last column / row
			x1_s2    <= (x0_d < wlast) ? x0_d + IDX_W'(1) : wlast;
			y1_s2    <= (y0_d < hlast) ? y0_d + IDX_W'(1) : hlast;
			fx_s2    <= tx_s1[FRAC_BITS-1:0];
			fy_s2    <= ty_s1[FRAC_BITS-1:0];
		end
	end

	// stage 3: memory addresses, then one memory access per cycle; a sample's first read waits for a free queue entry
	logic [ADDR_W-1:0]    row0_d, row1_d;
	logic                 v_s3, op_s3, white_s3, wok_s3;
	logic [ADDR_W-1:0]    waddr_s3;
	logic [31:0]          tval_s3;
	logic [ADDR_W-1:0]    a00_s3, a10_s3, a01_s3, a11_s3;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic [1:0]           rcnt_q;
	logic [CNT_W-1:0]     cred_q;
	logic                 credit_ok, normal_s3, rd_go, reserve, done_s3, mem_we;
	logic [ADDR_W-1:0]    raddr, mem_addr;

	assign row0_d = ADDR_W'(y0_s2) * ADDR_W'(width_q);
	assign row1_d = ADDR_W'(y1_s2) * ADDR_W'(width_q);

	assign credit_ok = cred_q < CNT_W'(FIFO_DEPTH);
	assign normal_s3 = (op_s3 == OP_SAMPLE) && !white_s3;
	assign rd_go     = v_s3 && normal_s3 && ((rcnt_q != 2'd0) || credit_ok);
	assign reserve   = v_s3 && (op_s3 == OP_SAMPLE) && (rcnt_q == 2'd0) && credit_ok;
	assign done_s3   = v_s3 && ((op_s3 == OP_LOAD) || (white_s3 && credit_ok) ||
		(normal_s3 && (rcnt_q == 2'd3)));
	assign ready_s3  = !v_s3 || done_s3;
	assign mem_we    = v_s3 && (op_s3 == OP_LOAD) && wok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			rcnt_q <= 2'd0;
		end else begin
			if (ready_s3) v_s3 <= v_s2;
			if (rd_go) rcnt_q <= rcnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && ready_s3) begin
			op_s3    <= op_s2;
			white_s3 <= white_s2;
			tval_s3  <= tval_s2;
			waddr_s3 <= ADDR_W'(taddr_s2);
			wok_s3   <= 32'(taddr_s2) < DEPTH;
			a00_s3   <= row0_d + ADDR_W'(x0_s2);
			a10_s3   <= row0_d + ADDR_W'(x1_s2);
			a01_s3   <= row1_d + ADDR_W'(x0_s2);
			a11_s3   <= row1_d + ADDR_W'(x1_s2);
			fx_s3    <= fx_s2;
			fy_s3    <= fy_s2;
		end
	end

	always_comb begin
		case (rcnt_q)
			2'd0: raddr = a00_s3;
			2'd1: raddr = a10_s3;
			2'd2: raddr = a01_s3;
			default: raddr = a11_s3;
		endcase
	end

	assign mem_addr = mem_we ? waddr_s3 : raddr;

	// single-port texture memory
	logic [31:0] tex_mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) tex_mem[mem_addr] <= tval_s3;
		if (rd_go) rdata_q <= tex_mem[mem_addr];
	end

	// gather the first three corners; the fourth is used straight from the read
	logic        rvalid_q;
	logic [1:0]  rtag_q;
	logic [31:0] col0_q, col1_q, col2_q;
	logic        bl_v_q, bl_white_q;
	logic [FRAC_BITS-1:0] bl_fx_q, bl_fy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			bl_v_q   <= 1'b0;
		end else begin
			rvalid_q <= rd_go;
			bl_v_q   <= done_s3 && (op_s3 == OP_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		rtag_q <= rcnt_q;
		if (rvalid_q) begin
			case (rtag_q)
				2'd0: col0_q <= rdata_q;
				2'd1: col1_q <= rdata_q;
				2'd2: col2_q <= rdata_q;
				default: begin
				end
			endcase
		end
		if (done_s3) begin
			bl_white_q <= white_s3;
			bl_fx_q    <= fx_s3;
			bl_fy_q    <= fy_s3;
		end
	end

	quad_t texels;
	logic  push;
	rgba_t push_color;

	assign texels = '{t11: rdata_q, t01: col2_q, t10: col1_q, t00: col0_q};

	bts_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.quad_valid  (bl_v_q),
		.quad_white  (bl_white_q),
		.fx          (bl_fx_q),
		.fy          (bl_fy_q),
		.texels      (texels),
		.chans       (chans_q),
		.color_valid (push),
		.color       (push_color)
	);

	// result queue; credits reserved at issue keep it from overflowing
	rgba_t            fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign pop = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			cred_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q  <= cnt_q + CNT_W'(push) - CNT_W'(pop);
			cred_q <= cred_q + CNT_W'(reserve) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= push_color;
	end

	assign rsp.valid = cnt_q != '0;
	assign rsp.red   = fifo_q[rd_ptr_q].red;
	assign rsp.green = fifo_q[rd_ptr_q].green;
	assign rsp.blue  = fifo_q[rd_ptr_q].blue;
	assign rsp.alpha = fifo_q[rd_ptr_q].alpha;

endmodule

@@ src/bts_blend.sv @@
module bts_blend #(
	parameter int unsigned FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  quad_valid,
	input  logic                  quad_white,
	input  logic [FRAC_BITS-1:0]  fx,
	input  logic [FRAC_BITS-1:0]  fy,
	input  bts_pkg::quad_t        texels,
	input  logic [2:0]            chans,
	output logic                  color_valid,
	output bts_pkg::rgba_t        color
);
	import bts_pkg::*;

	localparam int unsigned TW = FRAC_BITS + 8;
	localparam int unsigned HP = FRAC_BITS + 10;
	localparam int unsigned VP = 2 * FRAC_BITS + 10;
	localparam int unsigned SH = 2 * FRAC_BITS - 8;

	// a*(1-f) + b*f written as a*1 + (b-a)*f, exact
	function automatic logic [TW-1:0] lerp_byte(input logic [7:0] a, input logic [7:0] b,
		input logic [FRAC_BITS-1:0] f);
		logic signed [8:0]    diff;
		logic signed [HP-1:0] prod;
		logic signed [HP-1:0] base;
		logic signed [HP-1:0] sum;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = HP'(diff) * HP'($signed({1'b0, f}));
		base = $signed({2'b00, a, {FRAC_BITS{1'b0}}});
		sum  = base + prod;
		return sum[TW-1:0];
	endfunction

	function automatic logic [15:0] lerp_row(input logic [TW-1:0] t, input logic [TW-1:0] b,
		input logic [FRAC_BITS-1:0] f);
		logic signed [TW:0]   diff;
		logic signed [VP-1:0] prod;
		logic signed [VP-1:0] base;
		logic signed [VP-1:0] mix;
		diff = $signed({1'b0, b}) - $signed({1'b0, t});
		prod = VP'(diff) * VP'($signed({1'b0, f}));
		base = $signed({2'b00, t, {FRAC_BITS{1'b0}}});
		mix  = base + prod;
		return mix[SH+15:SH];
	endfunction

	logic [3:0][7:0]    c00, c10, c01, c11;
	logic [3:0][TW-1:0] top_d, bot_d;
	logic [3:0][15:0]   mix_d;

	logic                 v_s1;
	logic                 white_s1;
	logic [FRAC_BITS-1:0] fy_s1;
	logic [3:0][TW-1:0]   top_s1;
	logic [3:0][TW-1:0]   bot_s1;

	logic  v_s2;
	rgba_t color_s2;

	assign c00 = expand_texel(texels.t00, chans);
	assign c10 = expand_texel(texels.t10, chans);
	assign c01 = expand_texel(texels.t01, chans);
	assign c11 = expand_texel(texels.t11, chans);

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			top_d[c] = lerp_byte(c00[c], c10[c], fx);
			bot_d[c] = lerp_byte(c01[c], c11[c], fx);
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			mix_d[c] = lerp_row(top_s1[c], bot_s1[c], fy_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= quad_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		white_s1 <= quad_white;
		fy_s1    <= fy;
		top_s1   <= top_d;
		bot_s1   <= bot_d;
		if (white_s1) begin
			color_s2 <= '{alpha: FULL_OUT, blue: FULL_OUT, green: FULL_OUT, red: FULL_OUT};
		end else begin
			color_s2 <= '{alpha: mix_d[3], blue: mix_d[2], green: mix_d[1], red: mix_d[0]};
		end
	end

	assign color_valid = v_s2;
	assign color       = color_s2;

endmodule
